@@ rtl/rbst_pkg.sv @@
package rbst_pkg;

    // word format of all coordinates and ray parameters
    localparam int WORD_BITS = 32;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic        [WORD_BITS-1:0] mag_t;

    // saturation limits of a ray parameter
    localparam word_t T_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t T_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // ray parameter with a not-a-number mark (zero over zero)
    typedef struct packed {
        logic  nan;
        word_t v;
    } rbst_tval_t;

    // launch of one division lane
    typedef struct packed {
        logic start;
        logic zero_dir;
        logic nneg;
        logic neg;
        mag_t nmag;
        mag_t dmag;
    } rbst_div_req_t;

endpackage

@@ rtl/rbst_if.sv @@
interface rbst_item_if import rbst_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t slab_min;
    word_t slab_max;
    word_t ray_origin;
    word_t ray_direction;
    word_t start_t_min;
    word_t start_t_max;
    logic  first_axis;
    logic  last_axis;

    modport source (output valid, output slab_min, output slab_max, output ray_origin,
                    output ray_direction, output start_t_min, output start_t_max,
                    output first_axis, output last_axis, input ready);
    modport sink   (input valid, input slab_min, input slab_max, input ray_origin,
                    input ray_direction, input start_t_min, input start_t_max,
                    input first_axis, input last_axis, output ready);
endinterface

interface rbst_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, output hit, input ready);
    modport sink   (input valid, input hit, output ready);
endinterface

@@ rtl/rbst_div_lane.sv @@
module rbst_div_lane import rbst_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  rbst_div_req_t req,
    output logic          done,
    output rbst_tval_t    result
);

    localparam int CNT_W  = $clog2(WORD_BITS);
    localparam int WIDE_W = WORD_BITS + FRAC_BITS;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    mag_t                   rem_reg, rem_next;
    mag_t                   dmag_reg, dmag_next;
    logic [WORD_BITS-2:0]   feed_reg, feed_next;
    logic [WORD_BITS-2:0]   quo_reg, quo_next;
    logic                   neg_reg, neg_next;
    rbst_tval_t             res_reg, res_next;

    logic [WIDE_W-1:0]      wide;
    logic [FRAC_BITS:0]     head;
    logic                   head_ovf;
    logic [WORD_BITS:0]     trial;
    logic [WORD_BITS:0]     diff;
    logic                   take;
    logic [WORD_BITS-2:0]   quo_fin;
    word_t                  quo_pos;

    // scaled numerator: the head covers every quotient bit at or above the sign
    assign wide     = {req.nmag, {FRAC_BITS{1'b0}}};
    assign head     = wide[WIDE_W-1:WORD_BITS-1];
    assign head_ovf = (WORD_BITS'(head) >= req.dmag);

    // one restoring step per cycle
    assign trial   = {rem_reg, feed_reg[WORD_BITS-2]};
    assign diff    = trial - {1'b0, dmag_reg};
    assign take    = ~diff[WORD_BITS];
    assign quo_fin = {quo_reg[WORD_BITS-3:0], take};
    assign quo_pos = {1'b0, quo_fin};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        feed_next = feed_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (req.start)
        begin
            dmag_next = req.dmag;
            neg_next  = req.neg;
            cnt_next  = '0;
            quo_next  = '0;
            rem_next  = WORD_BITS'(head);
            feed_next = wide[WORD_BITS-2:0];
            if (req.zero_dir)
            begin
                // zero direction: signed limit, or not a number for zero over zero
                done_next    = 1'b1;
                busy_next    = 1'b0;
                res_next.nan = (req.nmag == '0);
                res_next.v   = req.nneg ? T_MIN : T_MAX;
            end
            else if (head_ovf)
            begin
                // quotient magnitude reaches the sign weight, saturate
                done_next    = 1'b1;
                busy_next    = 1'b0;
                res_next.nan = 1'b0;
                res_next.v   = req.neg ? T_MIN : T_MAX;
            end
            else
            begin
                done_next = 1'b0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            feed_next = {feed_reg[WORD_BITS-3:0], 1'b0};
            quo_next  = quo_fin;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_BITS - 2))
            begin
                busy_next    = 1'b0;
                done_next    = 1'b1;
                res_next.nan = 1'b0;
                res_next.v   = neg_reg ? -quo_pos : quo_pos;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        feed_reg <= feed_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/ray_box_slab_test.sv @@
// Ray against axis-aligned box, slab test, fed one axis per transfer.
// axis_item (sink): slab bounds, ray origin and direction of one axis in signed
//   fixed point; first_axis starts a new test and loads start_t_min/start_t_max,
//   last_axis closes it.
// hit_result (source): one transfer per last_axis item, hit = 1 when the ray
//   interval still overlaps the box.
// Items are taken one at a time. An axis that needs division keeps ready low
//   after its transfer through operand prep, launch, the divide step (two
//   lanes divide the entry and exit numerators by the direction in parallel,
//   one quotient bit per cycle over WORD_BITS-1 steps, then done), interval
//   update and miss check; a last axis also passes through the emit step.
//   Zero directions, saturated quotients and axes after a miss finish early.
// The result sits in an output register, so the next item is taken while it
//   waits.
// A stalled receiver holds only the following last_axis item, which waits in
//   the emit step until the output register is free.
// Reset clears the running interval to [0, 0] and the miss flag; a test begun
//   without first_axis therefore misses.
module ray_box_slab_test import rbst_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rbst_item_if.sink  axis_item,
    rbst_hit_if.source hit_result
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_LAUNCH = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_CHECK  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;
    word_t      run_min_reg, run_min_next;
    word_t      run_max_reg, run_max_next;
    logic       missed_reg, missed_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_hit_reg, out_hit_next;

    word_t      smin_reg, smax_reg, org_reg, dir_reg;
    logic       last_reg;
    mag_t       nmag0_reg, nmag1_reg, dmag_reg;
    logic       nneg0_reg, nneg1_reg, dneg_reg, dzero_reg;
    word_t      t0_v_reg, t1_v_reg;
    logic       t0_nan_reg, t1_nan_reg;

    logic [WORD_BITS:0] diff0, diff1, neg_diff0, neg_diff1;
    rbst_div_req_t      req0, req1;
    logic               done0, done1;
    rbst_tval_t         res0, res1;
    logic               accept;
    logic               pair_lt;
    word_t              lo_v, hi_v;
    logic               lo_nan, hi_nan;

    assign accept = axis_item.valid && axis_item.ready;
    assign axis_item.ready = (state_reg == ST_IDLE);

    // numerators one bit wider than a word, then split into sign and magnitude
    assign diff0     = {smin_reg[WORD_BITS-1], smin_reg} - {org_reg[WORD_BITS-1], org_reg};
    assign diff1     = {smax_reg[WORD_BITS-1], smax_reg} - {org_reg[WORD_BITS-1], org_reg};
    assign neg_diff0 = -diff0;
    assign neg_diff1 = -diff1;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smin_reg <= axis_item.slab_min;
            smax_reg <= axis_item.slab_max;
            org_reg  <= axis_item.ray_origin;
            dir_reg  <= axis_item.ray_direction;
            last_reg <= axis_item.last_axis;
        end
        if (state_reg == ST_PREP)
        begin
            nneg0_reg <= diff0[WORD_BITS];
            nneg1_reg <= diff1[WORD_BITS];
            nmag0_reg <= diff0[WORD_BITS] ? neg_diff0[WORD_BITS-1:0] : diff0[WORD_BITS-1:0];
            nmag1_reg <= diff1[WORD_BITS] ? neg_diff1[WORD_BITS-1:0] : diff1[WORD_BITS-1:0];
            dneg_reg  <= dir_reg[WORD_BITS-1];
            dmag_reg  <= dir_reg[WORD_BITS-1] ? mag_t'(-dir_reg) : mag_t'(dir_reg);
            dzero_reg <= (dir_reg == '0);
        end
        if (state_reg == ST_DIV)
        begin
            t0_v_reg   <= res0.v;
            t0_nan_reg <= res0.nan;
            t1_v_reg   <= res1.v;
            t1_nan_reg <= res1.nan;
        end
    end

    // division lanes for the entry and exit parameters
    always_comb
    begin
        req0.start    = (state_reg == ST_LAUNCH);
        req0.zero_dir = dzero_reg;
        req0.nneg     = nneg0_reg;
        req0.neg      = nneg0_reg ^ dneg_reg;
        req0.nmag     = nmag0_reg;
        req0.dmag     = dmag_reg;
        req1.start    = (state_reg == ST_LAUNCH);
        req1.zero_dir = dzero_reg;
        req1.nneg     = nneg1_reg;
        req1.neg      = nneg1_reg ^ dneg_reg;
        req1.nmag     = nmag1_reg;
        req1.dmag     = dmag_reg;
    end

    rbst_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane0 (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req0),
        .done   (done0),
        .result (res0)
    );

    rbst_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req1),
        .done   (done1),
        .result (res1)
    );

    // near and far parameter; a not-a-number side never narrows
    assign pair_lt = !t0_nan_reg && !t1_nan_reg && (t0_v_reg < t1_v_reg);
    assign lo_v    = pair_lt ? t0_v_reg : t1_v_reg;
    assign lo_nan  = pair_lt ? t0_nan_reg : t1_nan_reg;
    assign hi_v    = pair_lt ? t1_v_reg : t0_v_reg;
    assign hi_nan  = pair_lt ? t1_nan_reg : t0_nan_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        missed_next    = missed_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        if (hit_result.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (axis_item.first_axis)
                    begin
                        run_min_next = axis_item.start_t_min;
                        run_max_next = axis_item.start_t_max;
                        missed_next  = 1'b0;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (missed_reg)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (done0 && done1)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!lo_nan && (lo_v > run_min_reg))
                begin
                    run_min_next = lo_v;
                end
                if (!hi_nan && (hi_v < run_max_reg))
                begin
                    run_max_next = hi_v;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (run_max_reg <= run_min_reg)
                begin
                    missed_next = 1'b1;
                end
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || hit_result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = !missed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_min_reg   <= '0;
            run_max_reg   <= '0;
            missed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            missed_reg    <= missed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg <= out_hit_next;
    end

    assign hit_result.valid = out_valid_reg;
    assign hit_result.hit   = out_hit_reg;

    // a new test always starts without a miss
    a_first_clears_miss: assert property (@(posedge clk) disable iff (!rst_n)
        accept && axis_item.first_axis |=> !missed_reg)
        else $error("miss flag not cleared by first axis");

    // the miss is sticky until the next first axis
    a_miss_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        missed_reg && !(accept && axis_item.first_axis) |=> missed_reg)
        else $error("miss flag dropped inside a test");

    // only a last axis reaches the emit step
    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> last_reg)
        else $error("result emitted for an axis that is not last");

    // the interval is only loaded or narrowed, never widened within a test
    a_narrow_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=> (run_min_reg >= $past(run_min_reg))
                                 && (run_max_reg <= $past(run_max_reg)))
        else $error("ray interval widened by an axis");

endmodule

@@ tb/sv/testbench.sv @@
// one axis of a ray-box slab test as it crosses the item channel
typedef struct {
    rbst_pkg::word_t slab_min;
    rbst_pkg::word_t slab_max;
    rbst_pkg::word_t ray_origin;
    rbst_pkg::word_t ray_direction;
    rbst_pkg::word_t start_t_min;
    rbst_pkg::word_t start_t_max;
    bit              first_axis;
    bit              last_axis;
} axis_item_t;

// running ray interval of the block and the hit flags it still owes
class slab_hit_tracker;
    localparam int FRAC_BITS = 16;

    rbst_pkg::word_t span_lo = '0;
    rbst_pkg::word_t span_hi = '0;
    bit              missed = 1'b0;
    bit              hits_owed[$];
    int              failures = 0;
    int              mismatches = 0;

    // (bound - origin) / direction, truncated toward zero and saturated
    static function rbst_pkg::rbst_tval_t slab_param(rbst_pkg::word_t bound,
                                                     rbst_pkg::word_t origin,
                                                     rbst_pkg::word_t direction);
        rbst_pkg::rbst_tval_t t;
        longint               num;
        longint               den;
        logic [63:0]          nmag;
        logic [63:0]          dmag;
        logic [63:0]          quo;
        logic [31:0]          low;
        bit                   nneg;
        bit                   neg;
        num = longint'(bound) - longint'(origin);
        den = longint'(direction);
        t.nan = 1'b0;
        t.v = '0;
        nneg = (num < 0);
        nmag = nneg ? -num : num;
        // zero direction: signed saturation, or not-a-number on zero over zero
        if (den == 0)
        begin
            if (nmag == 0)
                t.nan = 1'b1;
            else
                t.v = nneg ? rbst_pkg::T_MIN : rbst_pkg::T_MAX;
            return t;
        end
        dmag = (den < 0) ? -den : den;
        neg = nneg ^ (den < 0);
        quo = (nmag << FRAC_BITS) / dmag;
        low = quo[31:0];
        if (!neg)
            t.v = (quo > 64'h0000_0000_7fff_ffff) ? rbst_pkg::T_MAX : rbst_pkg::word_t'(low);
        else
            t.v = (quo > 64'h0000_0000_8000_0000) ? rbst_pkg::T_MIN : rbst_pkg::word_t'(-low);
        return t;
    endfunction

    function int pending();
        return hits_owed.size();
    endfunction

    function void note_axis(axis_item_t a);
        rbst_pkg::rbst_tval_t t0;
        rbst_pkg::rbst_tval_t t1;
        rbst_pkg::word_t      v0;
        rbst_pkg::word_t      v1;
        if (a.first_axis)
        begin
            span_lo = a.start_t_min;
            span_hi = a.start_t_max;
            missed = 1'b0;
        end
        // narrow the interval unless the test already missed
        if (!missed)
        begin
            t0 = slab_param(a.slab_min, a.ray_origin, a.ray_direction);
            t1 = slab_param(a.slab_max, a.ray_origin, a.ray_direction);
            v0 = t0.v;
            v1 = t1.v;
            if (!t0.nan && !t1.nan && v0 < v1)
            begin
                if (v0 > span_lo)
                    span_lo = v0;
                if (v1 < span_hi)
                    span_hi = v1;
            end
            else
            begin
                if (!t1.nan && v1 > span_lo)
                    span_lo = v1;
                if (!t0.nan && v0 < span_hi)
                    span_hi = v0;
            end
            if (span_hi <= span_lo)
                missed = 1'b1;
        end
        if (a.last_axis)
            hits_owed.push_back(!missed);
    endfunction

    function void check_hit(bit got);
        bit want;
        if (hits_owed.size() == 0)
        begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: hit transfer with none owed, hit=%0b", $time, got);
            return;
        end
        want = hits_owed.pop_front();
        if (want != got)
        begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, got);
        end
    endfunction
endclass

module testbench;
    import rbst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    CYCLE_LIMIT = 1_000_000;
    localparam int    TAIL_CYCLES = 80;
    localparam int    RANDOM_AXES = 1450;
    localparam word_t ONE = 32'sh0001_0000;

    logic            clk = 1'b0;
    logic            rst_n;
    int unsigned     cycles = 0;
    bit              sender_burst = 1'b0;
    slab_hit_tracker tracker;

    rbst_item_if axis_if ();
    rbst_hit_if  hit_if ();

    ray_box_slab_test u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .axis_item  (axis_if),
        .hit_result (hit_if)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL ray_box_slab_test");
            $finish;
        end
    end

    // observe both channels; inputs first so a prediction is in place
    always @(posedge clk)
    begin
        axis_item_t seen;
        if (rst_n === 1'b1 && axis_if.valid && axis_if.ready)
        begin
            seen.slab_min = axis_if.slab_min;
            seen.slab_max = axis_if.slab_max;
            seen.ray_origin = axis_if.ray_origin;
            seen.ray_direction = axis_if.ray_direction;
            seen.start_t_min = axis_if.start_t_min;
            seen.start_t_max = axis_if.start_t_max;
            seen.first_axis = axis_if.first_axis;
            seen.last_axis = axis_if.last_axis;
            tracker.note_axis(seen);
        end
        if (rst_n === 1'b1 && hit_if.valid && hit_if.ready)
            tracker.check_hit(hit_if.hit);
    end

    // mostly short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(12, 70);
    endfunction

    function automatic word_t near(int unsigned span);
        return word_t'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    // field value anywhere in range, biased to the extremes
    function automatic word_t any_word();
        case ($urandom_range(0, 9))
            0: return T_MAX;
            1: return T_MIN;
            2: return '0;
            3: return $urandom_range(0, 1) ? ($urandom_range(0, 1) ? ONE : -ONE)
                                           : ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
            4, 5, 6: return word_t'($urandom);
            default: return near(32'h0100_0000);
        endcase
    endfunction

    // receiver back-pressure
    initial
    begin
        hit_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            int run;
            int gap;
            run = $urandom_range(1, 40);
            hit_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = idle_gap();
            if (gap > 0)
            begin
                hit_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // one item transfer, then an optional gap
    task automatic send_axis(input axis_item_t a);
        int gap;
        axis_if.valid <= 1'b1;
        axis_if.slab_min <= a.slab_min;
        axis_if.slab_max <= a.slab_max;
        axis_if.ray_origin <= a.ray_origin;
        axis_if.ray_direction <= a.ray_direction;
        axis_if.start_t_min <= a.start_t_min;
        axis_if.start_t_max <= a.start_t_max;
        axis_if.first_axis <= a.first_axis;
        axis_if.last_axis <= a.last_axis;
        do
            @(posedge clk);
        while (!axis_if.ready);
        gap = sender_burst ? 0 : idle_gap();
        if (gap > 0)
        begin
            axis_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(input word_t smin, input word_t smax, input word_t org,
                               input word_t dir, input word_t tlo, input word_t thi,
                               input bit first, input bit last);
        axis_item_t a;
        a.slab_min = smin;
        a.slab_max = smax;
        a.ray_origin = org;
        a.ray_direction = dir;
        a.start_t_min = tlo;
        a.start_t_max = thi;
        a.first_axis = first;
        a.last_axis = last;
        send_axis(a);
    endtask

    // hold off until every owed hit has arrived and the block has settled
    task automatic drain();
        axis_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // one ray-box test of random shape; broken ones get random markers
    task automatic run_ray(input int axes, input bit well_formed);
        axis_item_t a;
        word_t      c;
        word_t      h;
        word_t      tmp;
        for (int i = 0; i < axes; i++)
        begin
            c = near(40 * 65536);
            h = word_t'($urandom_range(1, 20 * 65536));
            a.slab_min = c - h;
            a.slab_max = c + h;
            if ($urandom_range(0, 9) == 0)
            begin
                tmp = a.slab_min;
                a.slab_min = a.slab_max;
                a.slab_max = tmp;
            end
            if ($urandom_range(0, 1))
                a.ray_origin = c + near(h);
            else
                a.ray_origin = near(60 * 65536);
            case ($urandom_range(0, 9))
                0: a.ray_direction = '0;
                1: a.ray_direction = any_word();
                default: a.ray_direction = near(4 * 65536);
            endcase
            a.start_t_min = $urandom_range(0, 3) ? word_t'(0) : near(8 * 65536);
            a.start_t_max = $urandom_range(0, 3) ? T_MAX
                                                 : word_t'($urandom_range(1, 32'h0100_0000));
            // noise content on some axes
            if ($urandom_range(0, 6) == 0)
            begin
                a.slab_min = any_word();
                a.slab_max = any_word();
                a.ray_origin = any_word();
                a.ray_direction = any_word();
                a.start_t_min = any_word();
                a.start_t_max = any_word();
            end
            if (well_formed)
            begin
                a.first_axis = (i == 0);
                a.last_axis = (i == axes - 1);
            end
            else
            begin
                a.first_axis = 1'($urandom_range(0, 1));
                a.last_axis = 1'($urandom_range(0, 1));
            end
            send_axis(a);
        end
    endtask

    initial
    begin
        int sent;
        int axes;
        bit paused;
        tracker = new;
        rst_n <= 1'b0;
        axis_if.valid <= 1'b0;
        axis_if.slab_min <= '0;
        axis_if.slab_max <= '0;
        axis_if.ray_origin <= '0;
        axis_if.ray_direction <= '0;
        axis_if.start_t_min <= '0;
        axis_if.start_t_max <= '0;
        axis_if.first_axis <= 1'b0;
        axis_if.last_axis <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // test closed without a first axis since reset: empty interval
        send_fields(-ONE, ONE, '0, ONE, '0, '0, 1'b0, 1'b1);
        // one-axis hit
        send_fields(-ONE, ONE, '0, ONE, '0, T_MAX, 1'b1, 1'b1);
        // zero direction with origin inside, below and above the slab
        send_fields(-ONE, ONE, '0, '0, '0, T_MAX, 1'b1, 1'b1);
        send_fields(ONE, 2 * ONE, '0, '0, '0, T_MAX, 1'b1, 1'b1);
        send_fields(-2 * ONE, -ONE, '0, '0, '0, T_MAX, 1'b1, 1'b1);
        // zero over zero on entry, on exit, on both
        send_fields('0, ONE, '0, '0, -ONE, T_MAX, 1'b1, 1'b1);
        send_fields(-ONE, '0, '0, '0, -ONE, ONE, 1'b1, 1'b1);
        send_fields(32'sd5, 32'sd5, 32'sd5, '0, -ONE, ONE, 1'b1, 1'b1);
        // quotient saturation both ways
        send_fields(T_MAX, T_MAX, T_MIN, 32'sd1, T_MIN, T_MAX, 1'b1, 1'b1);
        send_fields(T_MIN, T_MAX, T_MAX, -32'sd1, T_MIN, T_MAX, 1'b1, 1'b1);
        send_fields(T_MIN, T_MAX, '0, T_MIN, T_MIN, T_MAX, 1'b1, 1'b1);
        send_fields(T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, 1'b1, 1'b1);
        // starting interval already empty
        send_fields(-ONE, ONE, '0, ONE, T_MAX, T_MIN, 1'b1, 1'b1);
        // three-axis hit
        send_fields(-ONE, ONE, '0, ONE, '0, T_MAX, 1'b1, 1'b0);
        send_fields(-2 * ONE, 2 * ONE, '0, -ONE, '0, T_MAX, 1'b0, 1'b0);
        send_fields(-ONE, 3 * ONE, ONE, 2 * ONE, '0, T_MAX, 1'b0, 1'b1);
        // miss on the second axis stays through the third
        send_fields(-ONE, ONE, '0, ONE, '0, T_MAX, 1'b1, 1'b0);
        send_fields(4 * ONE, 5 * ONE, '0, -ONE, '0, T_MAX, 1'b0, 1'b0);
        send_fields(-ONE, ONE, '0, ONE, '0, T_MAX, 1'b0, 1'b1);
        // continuation without a new first axis keeps the miss
        send_fields(-ONE, ONE, '0, ONE, '0, T_MAX, 1'b0, 1'b1);
        // test left open, then a fresh one
        send_fields(-ONE, ONE, '0, ONE, '0, T_MAX, 1'b1, 1'b0);
        send_fields(-3 * ONE, -ONE, '0, 32'sh0000_8000, -ONE, T_MAX, 1'b1, 1'b1);
        drain();

        // random tests, mostly well formed
        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_AXES)
        begin
            axes = $urandom_range(1, 4);
            sender_burst = ($urandom_range(0, 4) == 0);
            run_ray(axes, $urandom_range(0, 9) != 0);
            sent += axes;
            if (!paused && sent >= RANDOM_AXES / 2)
            begin
                paused = 1'b1;
                drain();
            end
        end
        drain();

        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("PASS ray_box_slab_test");
        else
            $display("FAIL ray_box_slab_test");
        $finish;
    end
endmodule
